// ===== hdl/tcae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell encoder package
// Screen geometry, derived widths, shared types and character codes for the
// text cell to ANSI escape encoder.
// ----------------------------------------------------------------------------
package tcae_pkg;

    // Count the decimal digits of a positive value.
    function automatic int dec_digits(input int v);
        int n;
        int lim;
        n   = 1;
        lim = 10;
        for (int k = 0; k < 9; k++) begin
            if (v >= lim) begin
                n   = n + 1;
                lim = lim * 10;
            end
        end
        return n;
    endfunction

    // Screen geometry.
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

    // Width of a cell offset inside the window.
    localparam int OFF_W  = (SCREEN_CELLS > 1) ? $clog2(SCREEN_CELLS) : 1;
    // Width of a 1-based row or column number.
    localparam int MAX_RC = (SCREEN_COLUMNS > SCREEN_ROWS) ? SCREEN_COLUMNS : SCREEN_ROWS;
    localparam int NUM_W  = $clog2(MAX_RC + 1);
    // Decimal digits of a row or column number.
    localparam int DIG_N  = dec_digits(MAX_RC);
    localparam int BCD_W  = DIG_N * 4;
    // Digits of the number unit in the back end (color codes need three).
    localparam int NUM_DIG = (DIG_N > 3) ? DIG_N : 3;
    localparam int DIG_IW  = $clog2(NUM_DIG);

    // Port widths.
    localparam int ADDR_W     = 16;
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STYLING     = 1'b1;

    // Job queue between the front and back ends.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Stream characters.
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1b;
    localparam logic [BYTE_W-1:0] CH_LBR  = 8'h5b;
    localparam logic [BYTE_W-1:0] CH_S    = 8'h73;
    localparam logic [BYTE_W-1:0] CH_U    = 8'h75;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_H    = 8'h48;
    localparam logic [BYTE_W-1:0] CH_M    = 8'h6d;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

    // Classified cell content.
    typedef struct packed {
        logic [6:0]  chr;
        logic [11:0] fg_bcd;
        logic [11:0] bg_bcd;
        logic [7:0]  attrs;
        logic        styled;
        logic        err;
    } t_cell;

    // One job for the back end.
    typedef struct packed {
        t_cell            content;
        logic [BCD_W-1:0] row_bcd;
        logic [BCD_W-1:0] col_bcd;
    } t_job;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Back end sequencer states.
    typedef enum logic [4:0] {
        BK_IDLE,
        BK_SAVE_ESC,
        BK_SAVE_BR,
        BK_SAVE_S,
        BK_POS_ESC,
        BK_POS_BR,
        BK_NUM,
        BK_POS_SEMI,
        BK_POS_H,
        BK_SGR_ESC,
        BK_SGR_BR,
        BK_SGR_ZERO,
        BK_SGR_SEMI0,
        BK_FG_SEMI,
        BK_ATTR_SEMI,
        BK_SGR_M,
        BK_CHAR,
        BK_RST_ESC,
        BK_RST_BR,
        BK_RST_ZERO,
        BK_RST_M,
        BK_RES_ESC,
        BK_RES_BR,
        BK_RES_U
    } t_bk_state;

endpackage
`default_nettype wire

// ===== hdl/tcae_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell encoder front end
// Accepts writes, checks the window, splits the offset into row and column,
// converts both to decimal and classifies the styled word into a job.
// ----------------------------------------------------------------------------
module tcae_front
    import tcae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ADDR_W-1:0]  i_window_base,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [ADDR_W-1:0]  i_write_addr,
    input  wire logic [WORD_W-1:0]  i_styled_word,
    input  wire t_q_status          i_q_stat,
    output logic                    o_push,
    output t_job                    o_job
);

    localparam int RECIP  = (1 << OFF_W) / SCREEN_COLUMNS;
    localparam int M_W    = OFF_W + 1;
    localparam int PROD_W = OFF_W + M_W;
    localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
    localparam int PC_W   = NUM_W + COL_W;
    localparam int REM_W  = OFF_W + 1;
    localparam int DD_W   = BCD_W + NUM_W;

    // Map a 5-bit color to its SGR code in BCD; the top bit flags a bad color.
    function automatic logic [12:0] color_bcd(input logic [4:0] c, input logic bg);
        logic [3:0]  lo_n;
        logic [3:0]  lo_b;
        logic [11:0] dflt;
        logic [12:0] res;
        lo_n = 4'(c - 5'd1);
        lo_b = 4'(c - 5'd9);
        dflt = bg ? 12'h049 : 12'h039;
        if (c == 5'd0) begin
            res = {1'b0, dflt};
        end else if (c <= 5'd8) begin
            res = {1'b0, 4'h0, (bg ? 4'h4 : 4'h3), lo_n};
        end else if (c <= 5'd16) begin
            res = bg ? {1'b0, 4'h1, 4'h0, lo_b} : {1'b0, 4'h0, 4'h9, lo_b};
        end else begin
            res = {1'b1, dflt};
        end
        return res;
    endfunction

    // One shift-and-add-3 step of the binary to BCD conversion.
    function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
        logic [DD_W-1:0] y;
        y = x;
        for (int j = 0; j < DIG_N; j++) begin
            if (y[NUM_W + 4*j +: 4] >= 4'd5) begin
                y[NUM_W + 4*j +: 4] = y[NUM_W + 4*j +: 4] + 4'd3;
            end
        end
        return {y[DD_W-2:0], 1'b0};
    endfunction

    logic                w_en;
    logic [ADDR_W-1:0]   w_diff;
    logic [31:0]         w_diff32;
    logic                w_in;
    logic [OFF_W-1:0]    w_off;
    t_cell               w_cell;
    logic [12:0]         w_fg;
    logic [12:0]         w_bg;

    logic                r1_v;
    logic [OFF_W-1:0]    r1_off;
    t_cell               r1_cell;

    logic [PROD_W-1:0]   w_prod;
    logic                r2_v;
    logic [NUM_W-1:0]    r2_est;
    logic [OFF_W-1:0]    r2_off;
    t_cell               r2_cell;

    logic [PC_W-1:0]     w_pc;
    logic [REM_W-1:0]    w_rem;
    logic                w_wrap;
    logic [NUM_W-1:0]    w_row1;
    logic [NUM_W-1:0]    w_col1;

    logic [NUM_W:0]      r_dv;
    logic [DD_W-1:0]     r_drow [0:NUM_W];
    logic [DD_W-1:0]     r_dcol [0:NUM_W];
    t_cell               r_dcell [0:NUM_W];
    logic [DD_W-1:0]     w_srow [1:NUM_W];
    logic [DD_W-1:0]     w_scol [1:NUM_W];

    // The pipeline moves unless its last stage holds a job the queue cannot take.
    assign w_en   = !r_dv[NUM_W] || !i_q_stat.full;
    assign o_push = r_dv[NUM_W] && !i_q_stat.full;
    assign o_busy = !i_rst_n || !w_en;

    // Window check and cell classification.
    assign w_diff   = i_write_addr - i_window_base;
    assign w_diff32 = 32'(w_diff);
    assign w_in     = (i_write_addr >= i_window_base) && (w_diff32 < 32'(SCREEN_CELLS));
    assign w_off    = w_diff32[OFF_W-1:0];
    assign w_fg     = color_bcd(i_styled_word[12:8], 1'b0);
    assign w_bg     = color_bcd(i_styled_word[17:13], 1'b1);

    always_comb begin
        w_cell.chr    = i_styled_word[6:0];
        w_cell.fg_bcd = w_fg[11:0];
        w_cell.bg_bcd = w_bg[11:0];
        w_cell.attrs  = i_styled_word[25:18];
        w_cell.styled = |i_styled_word[WORD_W-1:7];
        w_cell.err    = w_fg[12] | w_bg[12];
    end

    // Row estimate by reciprocal multiplication; it is low by at most one.
    assign w_prod = PROD_W'(r1_off) * PROD_W'(RECIP);

    // Remainder and the single correction step.
    assign w_pc   = PC_W'(r2_est) * PC_W'(SCREEN_COLUMNS);
    assign w_rem  = REM_W'(r2_off) - REM_W'(w_pc);
    assign w_wrap = w_rem >= REM_W'(SCREEN_COLUMNS);
    assign w_row1 = r2_est + NUM_W'(w_wrap) + NUM_W'(1);
    assign w_col1 = w_wrap ? NUM_W'(w_rem - REM_W'(SCREEN_COLUMNS)) + NUM_W'(1)
                           : NUM_W'(w_rem) + NUM_W'(1);

    // Decimal conversion steps, one per stage.
    always_comb begin
        for (int k = 1; k <= NUM_W; k++) begin
            w_srow[k] = dd_step(r_drow[k-1]);
            w_scol[k] = dd_step(r_dcol[k-1]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_dv <= '0;
        end else if (w_en) begin
            r1_v <= i_start && w_in;
            r2_v <= r1_v;
            r_dv <= {r_dv[NUM_W-1:0], r2_v};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_off     <= w_off;
            r1_cell    <= w_cell;
            r2_est     <= NUM_W'(w_prod >> OFF_W);
            r2_off     <= r1_off;
            r2_cell    <= r1_cell;
            r_drow[0]  <= {BCD_W'(0), w_row1};
            r_dcol[0]  <= {BCD_W'(0), w_col1};
            r_dcell[0] <= r2_cell;
            for (int k = 1; k <= NUM_W; k++) begin
                r_drow[k]  <= w_srow[k];
                r_dcol[k]  <= w_scol[k];
                r_dcell[k] <= r_dcell[k-1];
            end
        end
    end

    // Finished job.
    always_comb begin
        o_job.content = r_dcell[NUM_W];
        o_job.row_bcd = r_drow[NUM_W][DD_W-1 -: BCD_W];
        o_job.col_bcd = r_dcol[NUM_W][DD_W-1 -: BCD_W];
    end

endmodule
`default_nettype wire

// ===== hdl/tcae_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell encoder job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module tcae_queue
    import tcae_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    input  wire logic   i_pop,
    output t_job        o_job,
    output t_q_status   o_stat
);

    t_job             r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_CW-1:0]  r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tcae_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell encoder back end
// Byte sequencer that turns one job into the escape stream, one byte a cycle,
// through a registered output stage.
// ----------------------------------------------------------------------------
module tcae_back
    import tcae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_styling,
    input  wire t_q_status          i_q_stat,
    input  wire t_job               i_job,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_last_byte,
    output logic                    o_color_error
);

    localparam int NUM_BW = NUM_DIG * 4;

    // SGR code of an attribute bit, in BCD.
    function automatic logic [7:0] attr_bcd(input logic [2:0] i);
        logic [7:0] res;
        case (i)
            3'd0:    res = 8'h01;
            3'd1:    res = 8'h02;
            3'd2:    res = 8'h03;
            3'd3:    res = 8'h04;
            3'd4:    res = 8'h05;
            3'd5:    res = 8'h08;
            3'd6:    res = 8'h09;
            3'd7:    res = 8'h53;
            default: res = 8'h01;
        endcase
        return res;
    endfunction

    // Index of the most significant nonzero digit, zero for a single digit.
    function automatic logic [DIG_IW-1:0] lead_dig(input logic [NUM_BW-1:0] v);
        logic [DIG_IW-1:0] idx;
        idx = '0;
        for (int k = 0; k < NUM_DIG; k++) begin
            if (v[4*k +: 4] != 4'd0) begin
                idx = DIG_IW'(k);
            end
        end
        return idx;
    endfunction

    t_bk_state           r_state, n_state;
    t_bk_state           r_ret, n_ret;
    t_cell               r_cell, n_cell;
    logic [BCD_W-1:0]    r_row, n_row;
    logic [BCD_W-1:0]    r_col, n_col;
    logic [7:0]          r_pend, n_pend;
    logic [NUM_BW-1:0]   r_num, n_num;
    logic [DIG_IW-1:0]   r_dig, n_dig;
    logic                r_err, n_err;
    logic                r_strobe, n_strobe;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_last, n_last;
    logic                r_cerr;

    logic                w_take;
    logic                w_sgr;
    logic [3:0]          w_digit;
    logic [2:0]          w_low;
    logic                w_do_load;
    logic [NUM_BW-1:0]   w_load;

    assign w_take  = !i_q_stat.empty;
    assign w_sgr   = r_cell.styled && i_styling;
    assign w_digit = r_num[{r_dig, 2'b00} +: 4];

    // Lowest pending attribute bit.
    always_comb begin
        w_low = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_low = 3'(k);
            end
        end
    end

    // Next state and byte selection.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_cell    = r_cell;
        n_row     = r_row;
        n_col     = r_col;
        n_pend    = r_pend;
        n_num     = r_num;
        n_dig     = r_dig;
        n_err     = r_err;
        n_strobe  = 1'b1;
        n_byte    = CH_ESC;
        n_last    = 1'b0;
        w_do_load = 1'b0;
        w_load    = '0;
        o_pop     = 1'b0;

        case (r_state)
            BK_IDLE: begin
                n_strobe = 1'b0;
                if (w_take) begin
                    o_pop   = 1'b1;
                    n_state = BK_SAVE_ESC;
                end
            end
            BK_SAVE_ESC: begin
                n_state = BK_SAVE_BR;
            end
            BK_SAVE_BR: begin
                n_byte  = CH_LBR;
                n_state = BK_SAVE_S;
            end
            BK_SAVE_S: begin
                n_byte  = CH_S;
                n_state = BK_POS_ESC;
            end
            BK_POS_ESC: begin
                n_state = BK_POS_BR;
            end
            BK_POS_BR: begin
                n_byte    = CH_LBR;
                w_do_load = 1'b1;
                w_load    = NUM_BW'(r_row);
                n_ret     = BK_POS_SEMI;
                n_state   = BK_NUM;
            end
            BK_NUM: begin
                n_byte = CH_ZERO | {4'h0, w_digit};
                if (r_dig == '0) begin
                    n_state = r_ret;
                end else begin
                    n_dig = r_dig - DIG_IW'(1);
                end
            end
            BK_POS_SEMI: begin
                n_byte    = CH_SEMI;
                w_do_load = 1'b1;
                w_load    = NUM_BW'(r_col);
                n_ret     = BK_POS_H;
                n_state   = BK_NUM;
            end
            BK_POS_H: begin
                n_byte  = CH_H;
                n_state = w_sgr ? BK_SGR_ESC : BK_CHAR;
            end
            BK_SGR_ESC: begin
                n_state = BK_SGR_BR;
            end
            BK_SGR_BR: begin
                n_byte  = CH_LBR;
                n_state = BK_SGR_ZERO;
            end
            BK_SGR_ZERO: begin
                n_byte  = CH_ZERO;
                n_state = BK_SGR_SEMI0;
            end
            BK_SGR_SEMI0: begin
                n_byte    = CH_SEMI;
                w_do_load = 1'b1;
                w_load    = NUM_BW'(r_cell.fg_bcd);
                n_ret     = BK_FG_SEMI;
                n_state   = BK_NUM;
            end
            BK_FG_SEMI: begin
                n_byte    = CH_SEMI;
                w_do_load = 1'b1;
                w_load    = NUM_BW'(r_cell.bg_bcd);
                n_ret     = (r_pend != 8'd0) ? BK_ATTR_SEMI : BK_SGR_M;
                n_state   = BK_NUM;
            end
            BK_ATTR_SEMI: begin
                n_byte    = CH_SEMI;
                w_do_load = 1'b1;
                w_load    = NUM_BW'(attr_bcd(w_low));
                n_pend    = r_pend & (r_pend - 8'd1);
                n_ret     = (n_pend != 8'd0) ? BK_ATTR_SEMI : BK_SGR_M;
                n_state   = BK_NUM;
            end
            BK_SGR_M: begin
                n_byte  = CH_M;
                n_state = BK_CHAR;
            end
            BK_CHAR: begin
                n_byte  = {1'b0, r_cell.chr};
                n_state = i_styling ? BK_RST_ESC : BK_RES_ESC;
            end
            BK_RST_ESC: begin
                n_state = BK_RST_BR;
            end
            BK_RST_BR: begin
                n_byte  = CH_LBR;
                n_state = BK_RST_ZERO;
            end
            BK_RST_ZERO: begin
                n_byte  = CH_ZERO;
                n_state = BK_RST_M;
            end
            BK_RST_M: begin
                n_byte  = CH_M;
                n_state = BK_RES_ESC;
            end
            BK_RES_ESC: begin
                n_state = BK_RES_BR;
            end
            BK_RES_BR: begin
                n_byte  = CH_LBR;
                n_state = BK_RES_U;
            end
            BK_RES_U: begin
                n_byte = CH_U;
                n_last = 1'b1;
                if (w_take) begin
                    o_pop   = 1'b1;
                    n_state = BK_SAVE_ESC;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_strobe = 1'b0;
                n_state  = BK_IDLE;
            end
        endcase

        // Start a decimal number.
        if (w_do_load) begin
            n_num = w_load;
            n_dig = lead_dig(w_load);
        end

        // Take the next job from the queue.
        if (o_pop) begin
            n_cell = i_job.content;
            n_row  = i_job.row_bcd;
            n_col  = i_job.col_bcd;
            n_pend = i_job.content.attrs;
            n_err  = i_job.content.styled && i_styling && i_job.content.err;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Job and output payload registers.
    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_cell <= n_cell;
        r_row  <= n_row;
        r_col  <= n_col;
        r_pend <= n_pend;
        r_num  <= n_num;
        r_dig  <= n_dig;
        r_err  <= n_err;
        r_byte <= n_byte;
        r_last <= n_last;
        r_cerr <= r_err;
    end

    assign o_strobe      = r_strobe;
    assign o_out_byte    = r_byte;
    assign o_last_byte   = r_last;
    assign o_color_error = r_cerr;

endmodule
`default_nettype wire

// ===== hdl/text_cell_to_ansi_escape_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell to ANSI escape encoder
// Turns writes to a memory-mapped text screen into a terminal byte stream.
// ----------------------------------------------------------------------------
// Usage:
// A write is transferred at a rising edge with start high and busy low. Writes
// outside the window are dropped and produce no bytes. Each accepted write
// yields 13 to 47 bytes: save cursor, cursor position, an optional SGR
// sequence, the character, an optional SGR reset and restore cursor.
// Each byte is on o_out_byte for one cycle with o_strobe high; o_last_byte
// marks the final byte of a write and o_color_error holds for all its bytes.
// The back end sends one byte per cycle; the front end takes a new write every
// cycle while the job queue has room, and busy rises only when the queue is
// full. The first byte passes the front pipeline, which carries one decimal
// conversion step per stage, then the job queue, the sequencer state register
// and the output register.
// The receiver cannot stall; bytes leave as they are produced.
// Registers are written on the configuration channel, which is always ready.
// Reset clears the pipeline and queue, sets window_base to 0 and turns
// styling on.
// ----------------------------------------------------------------------------
module text_cell_to_ansi_escape_encoder
    import tcae_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [ADDR_W-1:0]      i_write_addr,
    input  wire logic [WORD_W-1:0]      i_styled_word,
    output logic                        o_strobe,
    output logic [BYTE_W-1:0]           o_out_byte,
    output logic                        o_last_byte,
    output logic                        o_color_error,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [ADDR_W-1:0]  r_window_base;
    logic               r_styling;
    logic               w_push;
    logic               w_pop;
    t_job               w_fjob;
    t_job               w_qjob;
    t_q_status          w_q_stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= '0;
            r_styling     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_BASE: r_window_base <= i_cfg_data;
                CFG_STYLING:     r_styling     <= i_cfg_data[0];
                default:         r_styling     <= r_styling;
            endcase
        end
    end

    // Front end: window check, row and column, decimal conversion.
    tcae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_base (r_window_base),
        .i_start       (start),
        .o_busy        (busy),
        .i_write_addr  (i_write_addr),
        .i_styled_word (i_styled_word),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_job         (w_fjob)
    );

    // Job queue.
    tcae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_q_stat)
    );

    // Back end: byte sequencer.
    tcae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_styling     (r_styling),
        .i_q_stat      (w_q_stat),
        .i_job         (w_qjob),
        .o_pop         (w_pop),
        .o_strobe      (o_strobe),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_color_error (o_color_error)
    );

    // Every stream ends with the restore cursor sequence.
    a_last_is_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_byte) |-> (o_out_byte == CH_U) && ($past(o_out_byte) == CH_LBR))
        else $error("final byte of a write is not the restore cursor sequence");

    // The color error flag holds across all bytes of one write.
    a_err_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && !$past(o_last_byte))
            |-> (o_color_error == $past(o_color_error)))
        else $error("color error flag changed inside a write");

    // Writes are held off only while the job queue is full.
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_q_stat.full)
        else $error("busy raised while the job queue had room");

    // The queue is never popped while empty.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job queue popped while empty");

endmodule
`default_nettype wire

// ===== sim/tcae_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text cell encoder checker
// Watches the write, byte and register channels of the encoder. For every
// write transfer it predicts the terminal byte stream from its own copy of
// the registers, then compares each byte transfer field by field against the
// oldest predicted byte. Counts mismatches and reports how many bytes are
// still outstanding.
// ----------------------------------------------------------------------------
module tcae_checker
    import tcae_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [ADDR_W-1:0]      i_write_addr,
    input  logic [WORD_W-1:0]      i_styled_word,
    input  logic                   i_strobe,
    input  logic [BYTE_W-1:0]      i_out_byte,
    input  logic                   i_last_byte,
    input  logic                   i_color_error,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_bytes_outstanding,
    output int                     o_mismatch_count
);

    // SGR color bases.
    localparam int FG_DEFAULT = 39;
    localparam int BG_DEFAULT = 49;
    localparam int FG_NORMAL  = 30;
    localparam int BG_NORMAL  = 40;
    localparam int FG_BRIGHT  = 90;
    localparam int BG_BRIGHT  = 100;
    localparam int COLOR_MAX  = 16;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              color_err;
    } t_stream_byte;

    // Shadow copy of the configuration registers.
    logic [ADDR_W-1:0] window_base;
    logic              styling_on;

    // Bytes of the write being encoded, and all bytes still to arrive.
    logic [BYTE_W-1:0] cell_bytes[$];
    t_stream_byte      expected_bytes[$];

    initial begin
        o_bytes_outstanding = 0;
        o_mismatch_count    = 0;
    end

    // SGR code of each attribute flag, bold first.
    function automatic int attr_code(input int flag);
        case (flag)
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3:       return 4;
            4:       return 5;
            5:       return 8;
            6:       return 9;
            default: return 53;
        endcase
    endfunction

    // Colors beyond sixteen fall back to the default code.
    function automatic int color_code(input logic [4:0] color, input int dflt,
                                      input int normal, input int bright);
        if (color == 0)
            return dflt;
        if (color <= 8)
            return normal + int'(color) - 1;
        if (color <= COLOR_MAX)
            return bright + int'(color) - 9;
        return dflt;
    endfunction

    function automatic void emit_csi();
        cell_bytes.push_back(CH_ESC);
        cell_bytes.push_back(CH_LBR);
    endfunction

    // Decimal digits, most significant first, no leading zeros.
    function automatic void emit_number(input int value);
        logic [BYTE_W-1:0] digits[$];
        logic [BYTE_W-1:0] digit;
        int                rest;
        rest = value;
        do begin
            digit = CH_ZERO + BYTE_W'(rest % 10);
            digits.push_front(digit);
            rest = rest / 10;
        end while (rest != 0);
        foreach (digits[k])
            cell_bytes.push_back(digits[k]);
    endfunction

    // Predict the byte stream of one write and queue it.
    function automatic void encode_cell_write(input logic [ADDR_W-1:0] addr,
                                              input logic [WORD_W-1:0] word);
        int           offset;
        logic         color_bad;
        t_stream_byte item;
        if (addr < window_base)
            return;
        offset = int'(addr) - int'(window_base);
        if (offset >= SCREEN_CELLS)
            return;
        color_bad = 1'b0;
        cell_bytes.delete();

        // Save cursor, then move to the 1-based row and column.
        emit_csi();
        cell_bytes.push_back(CH_S);
        emit_csi();
        emit_number(offset / SCREEN_COLUMNS + 1);
        cell_bytes.push_back(CH_SEMI);
        emit_number(offset % SCREEN_COLUMNS + 1);
        cell_bytes.push_back(CH_H);

        // Any bit above the character asks for an SGR sequence.
        if (styling_on && word[WORD_W-1:7] != '0) begin
            color_bad = (word[12:8] > COLOR_MAX) || (word[17:13] > COLOR_MAX);
            emit_csi();
            cell_bytes.push_back(CH_ZERO);
            cell_bytes.push_back(CH_SEMI);
            emit_number(color_code(word[12:8], FG_DEFAULT, FG_NORMAL, FG_BRIGHT));
            cell_bytes.push_back(CH_SEMI);
            emit_number(color_code(word[17:13], BG_DEFAULT, BG_NORMAL, BG_BRIGHT));
            for (int flag = 0; flag < 8; flag++) begin
                if (word[18 + flag]) begin
                    cell_bytes.push_back(CH_SEMI);
                    emit_number(attr_code(flag));
                end
            end
            cell_bytes.push_back(CH_M);
        end

        cell_bytes.push_back({1'b0, word[6:0]});

        if (styling_on) begin
            emit_csi();
            cell_bytes.push_back(CH_ZERO);
            cell_bytes.push_back(CH_M);
        end

        // Restore cursor.
        emit_csi();
        cell_bytes.push_back(CH_U);

        foreach (cell_bytes[k]) begin
            item.data      = cell_bytes[k];
            item.last      = (k == cell_bytes.size() - 1);
            item.color_err = color_bad;
            expected_bytes.push_back(item);
        end
    endfunction

    // Track registers, check byte transfers and predict write transfers.
    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            window_base = '0;
            styling_on  = 1'b1;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_BASE: window_base = i_cfg_data[ADDR_W-1:0];
                    CFG_STYLING:     styling_on  = i_cfg_data[0];
                    default:         ;
                endcase
            end

            if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    $error("byte 0x%02h arrived with no write outstanding", i_out_byte);
                    o_mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.data) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               want.data, i_out_byte);
                        o_mismatch_count++;
                    end
                    if (i_last_byte !== want.last) begin
                        $error("last_byte: expected %0b, got %0b", want.last, i_last_byte);
                        o_mismatch_count++;
                    end
                    if (i_color_error !== want.color_err) begin
                        $error("color_error: expected %0b, got %0b",
                               want.color_err, i_color_error);
                        o_mismatch_count++;
                    end
                end
            end

            if (i_start && !i_busy)
                encode_cell_write(i_write_addr, i_styled_word);
        end
        o_bytes_outstanding = expected_bytes.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text cell encoder testbench
// Drives screen writes and register writes into the encoder: a directed set
// of corner cells, colors and attributes first, then random writes under
// several window and styling settings with varying sender gaps. The checker
// beside the block predicts and compares every byte; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import tcae_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    // Front pipeline plus queue latency, with margin for dropped writes.
    localparam int SETTLE_TICKS = 2 * (NUM_W + 5) + 10;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ADDR_W-1:0]     write_addr;
    logic [WORD_W-1:0]     styled_word;
    logic                  strobe;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last_byte;
    logic                  color_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    bytes_outstanding;
    int                    mismatch_count;
    int                    cycle_count = 0;

    text_cell_to_ansi_escape_encoder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_write_addr  (write_addr),
        .i_styled_word (styled_word),
        .o_strobe      (strobe),
        .o_out_byte    (out_byte),
        .o_last_byte   (last_byte),
        .o_color_error (color_error),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    tcae_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_write_addr        (write_addr),
        .i_styled_word       (styled_word),
        .i_strobe            (strobe),
        .i_out_byte          (out_byte),
        .i_last_byte         (last_byte),
        .i_color_error       (color_error),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_bytes_outstanding (bytes_outstanding),
        .o_mismatch_count    (mismatch_count)
    );

    // 8 ns clock.
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Run guard.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One write transfer; called and left at a falling edge. Start stays high
    // into the next call unless that call opens a gap.
    task automatic send_write(input logic [ADDR_W-1:0] addr,
                              input logic [WORD_W-1:0] word, input int gap_pct);
        if ($urandom_range(0, 99) < gap_pct) begin
            start       = 1'b0;
            write_addr  = ADDR_W'($urandom);
            styled_word = $urandom;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        start       = 1'b1;
        write_addr  = addr;
        styled_word = word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Lower start and wait until every predicted byte has come out, then let
    // the pipeline settle so that dropped writes are gone too.
    task automatic drain();
        start = 1'b0;
        while (bytes_outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = CFG_DATA_W'($urandom);
    endtask

    // Mostly cells inside the window; the rest land outside it or anywhere.
    task automatic pick_addr(input int base, output logic [ADDR_W-1:0] addr,
                             output logic in_window);
        int span;
        span = (65535 - base < SCREEN_CELLS - 1) ? 65535 - base : SCREEN_CELLS - 1;
        if ($urandom_range(0, 99) < 85) begin
            addr = ADDR_W'(base + int'($urandom_range(0, span)));
        end else if (base > 0 && $urandom_range(0, 1) == 1) begin
            addr = ADDR_W'($urandom_range(0, base - 1));
        end else if (base + SCREEN_CELLS <= 65535) begin
            addr = ADDR_W'($urandom_range(base + SCREEN_CELLS, 65535));
        end else begin
            addr = ADDR_W'($urandom);
        end
        in_window = (int'(addr) >= base) && (int'(addr) - base < SCREEN_CELLS);
    endtask

    // Plain characters, legal colors with attributes, bad colors, raw noise.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] word;
        int                kind;
        kind = $urandom_range(0, 99);
        word = $urandom_range(0, 127);
        if (kind < 20) begin
            return word;
        end else if (kind < 70) begin
            word[12:8]  = 5'($urandom_range(0, 16));
            word[17:13] = 5'($urandom_range(0, 16));
            word[25:18] = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                word[31:26] = 6'($urandom);
            return word;
        end else if (kind < 85) begin
            word[12:8]  = 5'($urandom_range(17, 31));
            word[17:13] = 5'($urandom_range(0, 31));
            word[25:18] = 8'($urandom);
            if ($urandom_range(0, 1) == 1)
                word[12:8] = 5'($urandom_range(0, 16));
            if (word[12:8] <= 16)
                word[17:13] = 5'($urandom_range(17, 31));
            return word;
        end
        return $urandom;
    endfunction

    task automatic run_phase(input int base, input logic styling, input int gap_pct,
                             input int cells);
        logic [ADDR_W-1:0] addr;
        logic              in_window;
        int                sent;
        drain();
        write_reg(CFG_WINDOW_BASE, CFG_DATA_W'(base));
        write_reg(CFG_STYLING, CFG_DATA_W'(styling));
        sent = 0;
        while (sent < cells) begin
            pick_addr(base, addr, in_window);
            send_write(addr, pick_word(), gap_pct);
            if (in_window)
                sent++;
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        start       = 1'b0;
        write_addr  = '0;
        styled_word = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WINDOW_BASE;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed writes under the reset settings: window at 0, styling on.
        send_write(16'd0, 32'h0000_0000, 0);        // character zero, no SGR
        send_write(16'd1999, 32'h0000_007f, 0);     // last cell
        send_write(16'd2000, 32'h0000_0041, 0);     // one past the window
        send_write(16'd79, 32'h0000_0041, 0);       // end of the first row
        send_write(16'd80, 32'h0000_0042, 0);       // start of the second row
        send_write(16'hffff, 32'h0000_0043, 0);     // top of the address space
        send_write(16'd1234, 32'h0000_0080, 0);     // unused bit still styles
        send_write(16'd5, 32'h0001_0141, 0);        // fg 1, bg 8
        send_write(16'd6, 32'h0002_095a, 0);        // fg 9, bg 16
        send_write(16'd7, 32'h0000_3061, 0);        // fg 16, bg 1
        send_write(16'd8, 32'h0000_1162, 0);        // fg above sixteen
        send_write(16'd9, 32'h0003_e063, 0);        // bg above sixteen
        send_write(16'd10, 32'h0003_ff64, 0);       // both colors maximal
        for (int flag = 0; flag < 8; flag++)
            send_write(ADDR_W'(100 + flag), (32'h1 << (18 + flag)) | (32'h61 + flag), 0);
        send_write(16'd12, 32'h03fc_007f, 0);       // every attribute
        send_write(16'd13, 32'h0400_0030, 0);       // bit above the attributes
        send_write(16'd14, 32'hffff_ffff, 0);       // every bit set
        send_write(16'd15, 32'hfc00_0000, 0);       // upper bits only

        // Random phases across window and styling settings and sender gaps.
        run_phase(65535 - (SCREEN_CELLS - 1), 1'b0, 0, 35);
        run_phase($urandom_range(1, 40000), 1'b1, 48, 40);
        run_phase(65535, 1'b1, 0, 15);
        run_phase(0, 1'b1, 32, 40);
        run_phase($urandom_range(0, 65535), 1'b0, 48, 30);

        drain();
        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
